@@ design/bounded_priority_queue_defines.svh @@
// ----------------------------------------------------------------------------
// Bounded priority queue: assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_PRIORITY_QUEUE_DEFINES_SVH
`define BOUNDED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define BPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset.
`define BPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/bpq_pkg.sv @@
// ----------------------------------------------------------------------------
// bpq_pkg
// Types, codes and defaults shared by the bounded priority queue.
// ----------------------------------------------------------------------------
package bpq_pkg;

  localparam int DEPTH_DEF        = 16;
  localparam int PAYLOAD_BITS_DEF = 32;
  localparam int PRIO_W           = 16;
  localparam int CFG_DATA_W       = 5;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    CFG_MAX_LEN   = 1'b0,
    CFG_PRIO_MODE = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic [1:0]               command;
    logic [31:0]              payload;
    logic signed [PRIO_W-1:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [31:0]              out_payload;
    logic signed [PRIO_W-1:0] out_priority;
    logic [4:0]               occupancy;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;  // capture the input item
    logic exec;  // apply the captured command
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } dp_stat_t;

endpackage

@@ design/bpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// bpq_ctrl
// Two-state sequencer: capture one command, then apply it once the result
// register has room.
// ----------------------------------------------------------------------------
module bpq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  bpq_pkg::dp_stat_t   stat,
  output logic                in_stall,
  output bpq_pkg::ctrl_cmd_t  cmd
);

  bpq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bpq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bpq_pkg::S_IDLE: begin
        if (in_valid) state_nxt = bpq_pkg::S_EXEC;
      end
      bpq_pkg::S_EXEC: begin
        if (stat.out_free) state_nxt = bpq_pkg::S_IDLE;
      end
      default: state_nxt = bpq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    unique case (state_r)
      bpq_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      bpq_pkg::S_EXEC: begin
        cmd.exec = stat.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

@@ design/bpq_dp.sv @@
// ----------------------------------------------------------------------------
// bpq_dp
// Shifting cell chain with entry count, configuration registers and the
// result register. Push opens a slot by shifting the tail up one cell, pop
// shifts every cell down toward the head.
// ----------------------------------------------------------------------------
module bpq_dp #(
  parameter int DEPTH        = bpq_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BITS = bpq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bpq_pkg::in_item_t                  in_data,
  input  logic                               cfg_we,
  input  logic                               cfg_idx,
  input  logic [bpq_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               out_stall,
  input  bpq_pkg::ctrl_cmd_t                 cmd,
  output bpq_pkg::dp_stat_t                  stat,
  output logic                               out_valid,
  output bpq_pkg::out_item_t                 out_data
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int LOGD = $clog2(DEPTH);

  // configuration
  logic [bpq_pkg::CFG_DATA_W-1:0] max_len_r;
  logic                           prio_mode_r;

  // cell chain, no reset: cells at or above the count are never read out
  logic [PAYLOAD_BITS-1:0]               cell_pay_r [DEPTH];
  logic signed [bpq_pkg::PRIO_W-1:0]     cell_pri_r [DEPTH];
  logic [CW-1:0]                         count_r, count_nxt;

  // captured command
  bpq_pkg::cmd_t                         cmd_r;
  logic [PAYLOAD_BITS-1:0]               pay_r;
  logic signed [bpq_pkg::PRIO_W-1:0]     pri_r;
  logic [DEPTH-1:0]                      gt_r, gt_nxt;

  // execute step
  logic [CW-1:0]       cap;
  logic                full;
  logic                empty;
  logic                do_push;
  logic                do_pop;
  logic [DEPTH-1:0]    mark;
  logic [DEPTH-1:0]    ge;
  logic [DEPTH-1:0]    ge_below;
  bpq_pkg::out_item_t  res;

  logic                out_valid_r;
  bpq_pkg::out_item_t  out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= '0;
      prio_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (bpq_pkg::cfg_idx_t'(cfg_idx))
        bpq_pkg::CFG_MAX_LEN:   max_len_r   <= cfg_wdata;
        bpq_pkg::CFG_PRIO_MODE: prio_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Per-cell compare against the incoming priority, done at capture.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt_nxt[i] = prio_mode_r && (CW'(i) < count_r) &&
                  (cell_pri_r[i] > in_data.priority_req);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= bpq_pkg::cmd_t'(in_data.command);
      pay_r <= PAYLOAD_BITS'(in_data.payload);
      pri_r <= in_data.priority_req;
      gt_r  <= gt_nxt;
    end
  end

  always_comb begin
    if (max_len_r == '0 || 32'(max_len_r) >= 32'(DEPTH)) begin
      cap = CW'(DEPTH);
    end else begin
      cap = CW'(max_len_r);
    end
    full  = (count_r >= cap);
    empty = (count_r == '0);
  end

  // Insert slot: first cell with a greater priority, else the tail.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      mark[i] = gt_r[i] || (CW'(i) == count_r);
    end
    ge = mark;
    for (int s = 0; s < LOGD; s++) begin
      ge = ge | (ge << (1 << s));
    end
    ge_below = ge << 1;
  end

  always_comb begin
    do_push       = 1'b0;
    do_pop        = 1'b0;
    count_nxt     = count_r;
    res           = '0;
    res.status    = bpq_pkg::ST_OK;
    unique case (cmd_r)
      bpq_pkg::CMD_PUSH: begin
        if (full) begin
          res.status = bpq_pkg::ST_FULL;
        end else begin
          do_push   = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      bpq_pkg::CMD_POP: begin
        if (empty) begin
          res.status = bpq_pkg::ST_EMPTY;
        end else begin
          do_pop           = 1'b1;
          count_nxt        = count_r - CW'(1);
          res.out_payload  = 32'(cell_pay_r[0]);
          res.out_priority = cell_pri_r[0];
        end
      end
      bpq_pkg::CMD_CLEAR: begin
        count_nxt = '0;
      end
      default: ;
    endcase
    res.occupancy = 5'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && do_push) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (ge[i] && !ge_below[i]) begin
          cell_pay_r[i] <= pay_r;
          cell_pri_r[i] <= pri_r;
        end else if (i > 0 && ge_below[i] && CW'(i) <= count_r) begin
          cell_pay_r[i] <= cell_pay_r[(i > 0) ? i - 1 : 0];
          cell_pri_r[i] <= cell_pri_r[(i > 0) ? i - 1 : 0];
        end
      end
    end else if (cmd.exec && do_pop) begin
      // advance every cell toward the head
      for (int i = 0; i < DEPTH - 1; i++) begin
        cell_pay_r[i] <= cell_pay_r[i + 1];
        cell_pri_r[i] <= cell_pri_r[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_r <= res;
    end
  end

  assign stat.out_free = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

endmodule

@@ design/bounded_priority_queue.sv @@
// ----------------------------------------------------------------------------
// bounded_priority_queue
// Bounded queue of payload and priority entries held in a shifting cell chain.
//
// Input channel (in_valid / in_stall / in_data): one command per transfer,
// push, pop or clear. Result channel (out_valid / out_stall / out_data): one
// result per command with status, popped entry and occupancy after it.
// Configuration (cfg_we / cfg_idx / cfg_wdata): index 0 is the entry limit
// (zero means DEPTH, values above DEPTH saturate), index 1 selects FIFO (0)
// or ascending priority (1) order. Write only while the queue is idle.
//
// Each command has a capture step (take it, compare its priority against
// every cell) and an execute step (shift the chain, load the result
// register); the result is visible the cycle after the execute step. A new
// command waits until the last one is applied; the execute step holds while
// the result register is full and stalled, so the receiver throttles input.
// Reset (rst_n low, synchronous) empties the queue, clears the limit to
// zero and selects FIFO order; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bounded_priority_queue #(
  parameter int DEPTH        = bpq_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BITS = bpq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bpq_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bpq_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic                           cfg_idx,
  input  logic [bpq_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  bpq_pkg::ctrl_cmd_t cmd;
  bpq_pkg::dp_stat_t  stat;

  bpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  bpq_dp #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ design/bpq_chk.sv @@
// ----------------------------------------------------------------------------
// bpq_chk
// Port-level checker for the bounded priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "bounded_priority_queue_defines.svh"

module bpq_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input bpq_pkg::out_item_t out_data
);

  `BPQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  `BPQ_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "command taken while busy")

  `BPQ_ASSERT_NOW(a_fail_no_data, out_valid && (out_data.status == bpq_pkg::ST_FULL || out_data.status == bpq_pkg::ST_EMPTY), out_data.out_payload == 32'd0 && out_data.out_priority == 16'sd0, "failed command returned data")

  `BPQ_ASSERT_NOW(a_empty_occ, out_valid && out_data.status == bpq_pkg::ST_EMPTY, out_data.occupancy == 5'd0, "empty pop with nonzero occupancy")

endmodule

bind bounded_priority_queue bpq_chk u_bpq_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// Bounded priority queue testbench
// Drives push, pop, clear and unused commands through the valid/stall input
// channel under several limit and order settings, keeps its own copy of
// the queue to predict each result, and checks every result transfer
// field by field.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = bpq_pkg::DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 50;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b1;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  bpq_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bpq_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_idx = 1'b0;
  logic [bpq_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // shadow copy of the queue
  logic [31:0] held_payload [DEPTH];
  logic signed [15:0] held_prio [DEPTH];
  int held_count = 0;
  int queue_limit = 0;
  bit prio_order = 1'b0;

  bpq_pkg::in_item_t command_queue [$];
  bpq_pkg::out_item_t expected_results [$];
  int sent_count = 0;
  int taken_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int cycle_count = 0;

  bounded_priority_queue i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic bpq_pkg::out_item_t apply_command(bpq_pkg::in_item_t item);
    bpq_pkg::out_item_t res;
    int cap;
    int slot;
    int k;
    res = '0;
    cap = (queue_limit == 0 || queue_limit >= DEPTH) ? DEPTH : queue_limit;
    unique case (item.command)
      bpq_pkg::CMD_PUSH: begin
        if (held_count >= cap) begin
          res.status = bpq_pkg::ST_FULL;
        end else begin
          slot = held_count;
          if (prio_order) begin
            // scan down so the first strictly greater entry wins
            for (k = held_count - 1; k >= 0; k--) begin
              if ($signed(held_prio[k]) > $signed(item.priority_req)) slot = k;
            end
          end
          for (k = held_count; k > slot; k--) begin
            held_payload[k] = held_payload[k-1];
            held_prio[k] = held_prio[k-1];
          end
          held_payload[slot] = item.payload;
          held_prio[slot] = item.priority_req;
          held_count++;
        end
      end
      bpq_pkg::CMD_POP: begin
        if (held_count == 0) begin
          res.status = bpq_pkg::ST_EMPTY;
        end else begin
          res.out_payload = held_payload[0];
          res.out_priority = held_prio[0];
          for (k = 1; k < held_count; k++) begin
            held_payload[k-1] = held_payload[k];
            held_prio[k-1] = held_prio[k];
          end
          held_count--;
        end
      end
      bpq_pkg::CMD_CLEAR: begin
        held_count = 0;
      end
      default: begin
      end
    endcase
    res.occupancy = held_count[4:0];
    return res;
  endfunction

  task automatic report_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
    if (exp_val !== got_val)
      $display("%0t: %s expected %h, got %h", $time, name, exp_val, got_val);
  endtask

  // monitor: predict on input transfers, check result transfers
  always @(posedge clk) begin
    bpq_pkg::out_item_t got;
    bpq_pkg::out_item_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = out_data;
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, got %h", $time, got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            errors++;
            report_field("status", 32'(want.status), 32'(got.status));
            report_field("payload", want.out_payload, got.out_payload);
            report_field("priority", 32'(want.out_priority), 32'(got.out_priority));
            report_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_command(in_data));
        taken_count <= taken_count + 1;
      end
    end
  end

  // driver: hold a presented item until its transfer, then advance
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || sent_count == taken_count) begin
        if (command_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= command_queue.pop_front();
          in_valid <= 1'b1;
          sent_count <= sent_count + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_reg(bpq_pkg::cfg_idx_t idx, logic [bpq_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == bpq_pkg::CFG_MAX_LEN) queue_limit = value;
    else prio_order = value[0];
  endtask

  task automatic queue_command(logic [1:0] cmd, logic [31:0] pay, logic [15:0] prio);
    bpq_pkg::in_item_t item;
    item.command = cmd;
    item.payload = pay;
    item.priority_req = prio;
    command_queue.push_back(item);
  endtask

  // check at the rising edge, where the driver's state is settled
  task automatic wait_drained();
    @(posedge clk);
    while (command_queue.size() != 0 || in_valid || sent_count != taken_count ||
           expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [15:0] random_prio();
    logic [15:0] extremes [4];
    extremes = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000};
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return extremes[$urandom_range(3)];
      default: return 16'(int'($urandom_range(6)) - 3);  // small range forces ties
    endcase
  endfunction

  task automatic queue_random(int push_pct);
    int roll;
    logic [1:0] cmd;
    roll = $urandom_range(99);
    if (roll < push_pct) cmd = bpq_pkg::CMD_PUSH;
    else if (roll < 94) cmd = bpq_pkg::CMD_POP;
    else if (roll < 97) cmd = bpq_pkg::CMD_CLEAR;
    else cmd = CMD_UNUSED;
    queue_command(cmd, $urandom, random_prio());
  endtask

  initial begin
    int limits [RANDOM_PHASES];
    bit modes [RANDOM_PHASES];
    limits = '{0, 16, 31, 1, 5, 3, 20, 0, 16};
    modes = '{1, 0, 1, 0, 1, 1, 0, 0, 1};
    send_idle_pct = 14;
    recv_stall_pct = 55;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // FIFO with a limit of two: full, empty, unused code, clear
    write_reg(bpq_pkg::CFG_MAX_LEN, 5'd2);
    write_reg(bpq_pkg::CFG_PRIO_MODE, 5'd0);
    queue_command(bpq_pkg::CMD_PUSH, 32'hFFFF_FFFF, 16'h7FFF);
    queue_command(bpq_pkg::CMD_PUSH, 32'h0000_0000, 16'h8000);
    queue_command(bpq_pkg::CMD_PUSH, 32'hA5A5_5A5A, 16'h0000);
    queue_command(bpq_pkg::CMD_POP, 32'h0, 16'h0);
    queue_command(bpq_pkg::CMD_POP, 32'h0, 16'h0);
    queue_command(bpq_pkg::CMD_POP, 32'hFFFF_FFFF, 16'hFFFF);
    queue_command(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
    queue_command(bpq_pkg::CMD_CLEAR, 32'h0, 16'h0);
    wait_drained();

    // priority order: extremes and a tie that keeps arrival order
    write_reg(bpq_pkg::CFG_MAX_LEN, 5'd0);
    write_reg(bpq_pkg::CFG_PRIO_MODE, 5'd1);
    queue_command(bpq_pkg::CMD_PUSH, 32'd1, 16'h7FFF);
    queue_command(bpq_pkg::CMD_PUSH, 32'd2, 16'h8000);
    queue_command(bpq_pkg::CMD_PUSH, 32'd3, 16'h0000);
    queue_command(bpq_pkg::CMD_PUSH, 32'd4, 16'h0000);
    queue_command(bpq_pkg::CMD_PUSH, 32'd5, 16'hFFFF);
    repeat (6) queue_command(bpq_pkg::CMD_POP, 32'h0, 16'h0);
    queue_command(bpq_pkg::CMD_PUSH, 32'd6, 16'd5);
    queue_command(bpq_pkg::CMD_CLEAR, 32'h0, 16'h0);
    queue_command(bpq_pkg::CMD_POP, 32'h0, 16'h0);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 3) begin
        send_idle_pct = 55;
        recv_stall_pct = 14;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      write_reg(bpq_pkg::CFG_MAX_LEN, 5'(limits[p]));
      write_reg(bpq_pkg::CFG_PRIO_MODE, 5'(modes[p]));
      // fill toward the limit, then drain
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        queue_random(n < ITEMS_PER_PHASE / 2 ? 70 : 35);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/bpq_pkg.sv
design/bpq_ctrl.sv
design/bpq_dp.sv
design/bounded_priority_queue.sv
design/bpq_chk.sv
verif/testbench.sv
